// ===== rtl/stt_pkg.sv =====
package stt_pkg;

    localparam int OUT_INDEX_W = 32;
    localparam int OUT_POS_W   = 24;
    localparam int EXT_W       = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam logic [3:0] KW_FUNC_LEN = 4'd8;
    localparam logic [3:0] KW_RET_LEN  = 4'd6;

    localparam logic [63:0] LIMIT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_NEG = 64'h8000_0000_0000_0000;

    typedef enum logic [3:0] {
        KIND_SPACE   = 4'd0,
        KIND_FUNC    = 4'd1,
        KIND_RETURN  = 4'd2,
        KIND_IDENT   = 4'd3,
        KIND_POS_INT = 4'd4,
        KIND_NEG_INT = 4'd5,
        KIND_POS_DBL = 4'd6,
        KIND_NEG_DBL = 4'd7,
        KIND_COMMENT = 4'd8,
        KIND_SYMBOL  = 4'd9,
        KIND_EOF     = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SPACE   = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_COMMENT = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        t_kind              token_kind;
        logic [31:0]        start_index;
        logic [31:0]        token_length;
        logic [23:0]        start_row;
        logic [23:0]        start_column;
        logic signed [63:0] integer_value;
        logic [7:0]         symbol_byte;
        logic               malformed;
        logic               last_of_step;
    } t_out;

    typedef struct packed {
        logic neg;
        logic dot;
        logic digit;
        logic ovf;
    } t_num_flags;

    typedef struct packed {
        logic [3:0] prog;
        logic       func_ok;
        logic       ret_ok;
    } t_kw_state;

    typedef struct packed {
        logic first_vld;
        logic second_vld;
    } t_push;

    function automatic logic [7:0] kw_func_char(input logic [3:0] p);
        logic [7:0] ch;
        case (p)
            4'd0:    ch = 8'h66;
            4'd1:    ch = 8'h75;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h63;
            4'd4:    ch = 8'h74;
            4'd5:    ch = 8'h69;
            4'd6:    ch = 8'h6F;
            4'd7:    ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_ret_char(input logic [3:0] p);
        logic [7:0] ch;
        case (p)
            4'd0:    ch = 8'h72;
            4'd1:    ch = 8'h65;
            4'd2:    ch = 8'h74;
            4'd3:    ch = 8'h75;
            4'd4:    ch = 8'h72;
            4'd5:    ch = 8'h6E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // largest accumulator that still takes one more digit: (limit - d) / 10
    function automatic logic [63:0] digit_bound(input logic neg, input logic [3:0] d);
        logic [3:0] last_safe;
        last_safe = neg ? 4'd8 : 4'd7;
        return (d > last_safe) ? 64'd922337203685477579 : 64'd922337203685477580;
    endfunction

endpackage

// ===== rtl/stt_result_queue.sv =====
module stt_result_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stt_pkg::t_push              i_push,
    input  stt_pkg::t_out               i_first,
    input  stt_pkg::t_out               i_second,
    output logic [stt_pkg::QUEUE_AW:0]  o_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output stt_pkg::t_out               o_data
);

    stt_pkg::t_out                 r_mem [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QUEUE_AW-1:0]  r_wr;
    logic [stt_pkg::QUEUE_AW-1:0]  r_rd;
    logic [stt_pkg::QUEUE_AW:0]    r_count;
    logic [stt_pkg::QUEUE_AW-1:0]  w_second_addr;
    logic                          w_pop;

    assign w_pop         = o_valid && i_ready;
    assign w_second_addr = r_wr + stt_pkg::QUEUE_AW'(i_push.first_vld);
    assign o_valid       = (r_count != '0);
    assign o_count       = r_count;
    assign o_data        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.first_vld) begin
            r_mem[r_wr] <= i_first;
        end
        if (i_push.second_vld) begin
            r_mem[w_second_addr] <= i_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + stt_pkg::QUEUE_AW'(i_push.first_vld)
                            + stt_pkg::QUEUE_AW'(i_push.second_vld);
            r_rd    <= r_rd + stt_pkg::QUEUE_AW'(w_pop);
            r_count <= r_count + (stt_pkg::QUEUE_AW+1)'(i_push.first_vld)
                               + (stt_pkg::QUEUE_AW+1)'(i_push.second_vld)
                               - (stt_pkg::QUEUE_AW+1)'(w_pop);
        end
    end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// flow: a taken request waits in the input register and is scanned from there once
//   the result queue has room; its tokens are written into that queue and offered from it
// throughput: one request per cycle while tokens drain one per cycle and the queue holds
//   at most two entries; a request that closes a token and opens a symbol (or ends the
//   stream) yields two tokens, the four-entry result queue absorbing bursts
// reset: synchronous, active low; scanner idle, all counters zero, queue empty
module source_text_tokenizer #(
    parameter int INDEX_WIDTH    = 32,
    parameter int POSITION_WIDTH = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  stt_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output stt_pkg::t_out  o_out_data
);

    // input register
    logic          r_in_vld;
    stt_pkg::t_in  r_in;

    // scanner state
    stt_pkg::t_mode       r_mode,    n_mode;
    logic [INDEX_WIDTH-1:0]    r_tok_idx, n_tok_idx;
    logic [POSITION_WIDTH-1:0] r_tok_row, n_tok_row;
    logic [POSITION_WIDTH-1:0] r_tok_col, n_tok_col;
    logic [INDEX_WIDTH-1:0]    r_byte_cnt, n_byte_cnt;
    logic [POSITION_WIDTH-1:0] r_row_cnt, n_row_cnt;
    logic [POSITION_WIDTH-1:0] r_col_cnt, n_col_cnt;
    logic [63:0]               r_acc, n_acc;
    stt_pkg::t_num_flags  r_flags,   n_flags;
    stt_pkg::t_kw_state   r_kw,      n_kw;

    logic [stt_pkg::QUEUE_AW:0] w_q_count;
    logic                       w_fire;
    logic                       w_take;

    // character classes
    logic [7:0] w_c;
    logic       w_eos;
    logic       w_is_space, w_is_alpha, w_is_digit, w_is_num_start, w_is_hash, w_is_sym;
    logic       w_cont;

    // shared digit and keyword steps
    logic [63:0]          w_dg_acc_in, w_dg_acc_out, w_dg_limit;
    stt_pkg::t_num_flags  w_dg_flags_in, w_dg_flags_out, w_begin_flags;
    stt_pkg::t_kw_state   w_kw_in, w_kw_out;

    // outgoing records
    stt_pkg::t_out   w_pend, w_second;
    stt_pkg::t_push  w_push;
    logic            w_pend_vld;
    logic [INDEX_WIDTH-1:0] w_len;

    // widened copies for the fixed-width output fields
    logic [stt_pkg::EXT_W-1:0] w_tok_idx_ext, w_byte_ext, w_len_ext;
    logic [stt_pkg::EXT_W-1:0] w_tok_row_ext, w_tok_col_ext, w_row_ext, w_col_ext;

    // ---------------------------------------------------------------
    // input side: the register frees whenever its request is scanned
    // ---------------------------------------------------------------
    assign w_fire     = r_in_vld && (w_q_count <= (stt_pkg::QUEUE_AW+1)'(stt_pkg::QUEUE_DEPTH - 2));
    assign o_in_ready = !r_in_vld || w_fire;
    assign w_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // classify the byte
    // ---------------------------------------------------------------
    assign w_c            = r_in.char_code;
    assign w_eos          = r_in.end_of_stream;
    assign w_is_space     = (w_c == 8'd32) || (w_c >= 8'd9 && w_c <= 8'd13);
    assign w_is_alpha     = (w_c >= 8'd65 && w_c <= 8'd90) || (w_c >= 8'd97 && w_c <= 8'd122);
    assign w_is_digit     = (w_c >= 8'd48 && w_c <= 8'd57);
    assign w_is_num_start = w_is_digit || (w_c == stt_pkg::CHAR_DOT)
                            || (w_c == stt_pkg::CHAR_MINUS);
    assign w_is_hash      = (w_c == stt_pkg::CHAR_HASH);
    assign w_is_sym       = !w_is_space && !w_is_alpha && !w_is_num_start && !w_is_hash;

    // does the byte extend the open token
    always_comb begin
        case (r_mode)
            stt_pkg::MODE_SPACE:   w_cont = w_is_space;
            stt_pkg::MODE_IDENT:   w_cont = w_is_alpha || w_is_digit;
            stt_pkg::MODE_NUMBER:  w_cont = w_is_digit
                                            || ((w_c == stt_pkg::CHAR_DOT) && !r_flags.dot);
            stt_pkg::MODE_COMMENT: w_cont = (w_c != stt_pkg::CHAR_LF)
                                            && (w_c != stt_pkg::CHAR_CR);
            default:               w_cont = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // digit step: saturating acc * 10 + d, shared by start and continue
    // ---------------------------------------------------------------
    assign w_begin_flags = '{neg: (w_c == stt_pkg::CHAR_MINUS), dot: (w_c == stt_pkg::CHAR_DOT),
                             digit: 1'b0, ovf: 1'b0};
    assign w_dg_acc_in   = w_cont ? r_acc : 64'd0;
    assign w_dg_flags_in = w_cont ? r_flags : w_begin_flags;
    assign w_dg_limit    = w_dg_flags_in.neg ? stt_pkg::LIMIT_NEG : stt_pkg::LIMIT_POS;

    always_comb begin
        w_dg_flags_out       = w_dg_flags_in;
        w_dg_flags_out.digit = 1'b1;
        w_dg_acc_out         = w_dg_acc_in;
        if (!w_dg_flags_in.dot) begin
            if (w_dg_acc_in > stt_pkg::digit_bound(w_dg_flags_in.neg, w_c[3:0])) begin
                // saturate and remember it
                w_dg_acc_out       = w_dg_limit;
                w_dg_flags_out.ovf = 1'b1;
            end else begin
                w_dg_acc_out = (w_dg_acc_in << 3) + (w_dg_acc_in << 1) + {60'd0, w_c[3:0]};
            end
        end
    end

    // keyword tracking: one byte compared against both words
    assign w_kw_in = w_cont ? r_kw : '{prog: 4'd0, func_ok: 1'b1, ret_ok: 1'b1};

    always_comb begin
        w_kw_out = w_kw_in;
        if (!(w_kw_in.prog < stt_pkg::KW_FUNC_LEN && w_c == stt_pkg::kw_func_char(w_kw_in.prog))) begin
            w_kw_out.func_ok = 1'b0;
        end
        if (!(w_kw_in.prog < stt_pkg::KW_RET_LEN && w_c == stt_pkg::kw_ret_char(w_kw_in.prog))) begin
            w_kw_out.ret_ok = 1'b0;
        end
        if (w_kw_in.prog != 4'd15) begin
            w_kw_out.prog = w_kw_in.prog + 4'd1;
        end
    end

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_mode     = r_mode;
        n_tok_idx  = r_tok_idx;
        n_tok_row  = r_tok_row;
        n_tok_col  = r_tok_col;
        n_byte_cnt = r_byte_cnt;
        n_row_cnt  = r_row_cnt;
        n_col_cnt  = r_col_cnt;
        n_acc      = r_acc;
        n_flags    = r_flags;
        n_kw       = r_kw;
        if (w_fire) begin
            if (w_eos) begin
                // stream closed: back to the state after reset
                n_mode     = stt_pkg::MODE_IDLE;
                n_tok_idx  = '0;
                n_tok_row  = '0;
                n_tok_col  = '0;
                n_byte_cnt = '0;
                n_row_cnt  = '0;
                n_col_cnt  = '0;
                n_acc      = '0;
                n_flags    = '0;
                n_kw       = '0;
            end else begin
                if (w_cont) begin
                    if (r_mode == stt_pkg::MODE_IDENT) begin
                        n_kw = w_kw_out;
                    end else if (r_mode == stt_pkg::MODE_NUMBER) begin
                        if (w_c == stt_pkg::CHAR_DOT) begin
                            n_flags.dot = 1'b1;
                        end else begin
                            n_acc   = w_dg_acc_out;
                            n_flags = w_dg_flags_out;
                        end
                    end
                end else begin
                    // open a new token at the current position
                    n_tok_idx = r_byte_cnt;
                    n_tok_row = r_row_cnt;
                    n_tok_col = r_col_cnt;
                    if (w_is_space) begin
                        n_mode = stt_pkg::MODE_SPACE;
                    end else if (w_is_alpha) begin
                        n_mode = stt_pkg::MODE_IDENT;
                        n_kw   = w_kw_out;
                    end else if (w_is_num_start) begin
                        n_mode = stt_pkg::MODE_NUMBER;
                        if (w_is_digit) begin
                            n_acc   = w_dg_acc_out;
                            n_flags = w_dg_flags_out;
                        end else begin
                            n_acc   = '0;
                            n_flags = w_begin_flags;
                        end
                    end else if (w_is_hash) begin
                        n_mode = stt_pkg::MODE_COMMENT;
                    end else begin
                        n_mode = stt_pkg::MODE_IDLE;
                    end
                end
                n_byte_cnt = r_byte_cnt + INDEX_WIDTH'(1);
                if (w_c == stt_pkg::CHAR_LF) begin
                    n_col_cnt = '0;
                    n_row_cnt = r_row_cnt + POSITION_WIDTH'(1);
                end else begin
                    n_col_cnt = r_col_cnt + POSITION_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= stt_pkg::MODE_IDLE;
            r_tok_idx  <= '0;
            r_tok_row  <= '0;
            r_tok_col  <= '0;
            r_byte_cnt <= '0;
            r_row_cnt  <= '0;
            r_col_cnt  <= '0;
            r_acc      <= '0;
            r_flags    <= '0;
            r_kw       <= '0;
        end else begin
            r_mode     <= n_mode;
            r_tok_idx  <= n_tok_idx;
            r_tok_row  <= n_tok_row;
            r_tok_col  <= n_tok_col;
            r_byte_cnt <= n_byte_cnt;
            r_row_cnt  <= n_row_cnt;
            r_col_cnt  <= n_col_cnt;
            r_acc      <= n_acc;
            r_flags    <= n_flags;
            r_kw       <= n_kw;
        end
    end

    // ---------------------------------------------------------------
    // outgoing tokens
    // ---------------------------------------------------------------
    assign w_len         = r_byte_cnt - r_tok_idx;
    assign w_tok_idx_ext = {{(stt_pkg::EXT_W-INDEX_WIDTH){1'b0}}, r_tok_idx};
    assign w_byte_ext    = {{(stt_pkg::EXT_W-INDEX_WIDTH){1'b0}}, r_byte_cnt};
    assign w_len_ext     = {{(stt_pkg::EXT_W-INDEX_WIDTH){1'b0}}, w_len};
    assign w_tok_row_ext = {{(stt_pkg::EXT_W-POSITION_WIDTH){1'b0}}, r_tok_row};
    assign w_tok_col_ext = {{(stt_pkg::EXT_W-POSITION_WIDTH){1'b0}}, r_tok_col};
    assign w_row_ext     = {{(stt_pkg::EXT_W-POSITION_WIDTH){1'b0}}, r_row_cnt};
    assign w_col_ext     = {{(stt_pkg::EXT_W-POSITION_WIDTH){1'b0}}, r_col_cnt};

    assign w_pend_vld = (r_mode != stt_pkg::MODE_IDLE);

    // the open token, closed by this byte or by the end mark
    always_comb begin
        w_pend               = '0;
        w_pend.start_index   = w_tok_idx_ext[stt_pkg::OUT_INDEX_W-1:0];
        w_pend.token_length  = w_len_ext[stt_pkg::OUT_INDEX_W-1:0];
        w_pend.start_row     = w_tok_row_ext[stt_pkg::OUT_POS_W-1:0];
        w_pend.start_column  = w_tok_col_ext[stt_pkg::OUT_POS_W-1:0];
        w_pend.last_of_step  = !w_push.second_vld;
        unique case (r_mode)
            stt_pkg::MODE_IDENT: begin
                if (r_kw.func_ok && r_kw.prog == stt_pkg::KW_FUNC_LEN) begin
                    w_pend.token_kind = stt_pkg::KIND_FUNC;
                end else if (r_kw.ret_ok && r_kw.prog == stt_pkg::KW_RET_LEN) begin
                    w_pend.token_kind = stt_pkg::KIND_RETURN;
                end else begin
                    w_pend.token_kind = stt_pkg::KIND_IDENT;
                end
            end
            stt_pkg::MODE_NUMBER: begin
                if (r_flags.dot) begin
                    w_pend.token_kind = r_flags.neg ? stt_pkg::KIND_NEG_DBL
                                                    : stt_pkg::KIND_POS_DBL;
                end else begin
                    w_pend.token_kind    = r_flags.neg ? stt_pkg::KIND_NEG_INT
                                                       : stt_pkg::KIND_POS_INT;
                    w_pend.integer_value = r_flags.neg ? (64'd0 - r_acc) : r_acc;
                end
                // no digit at all, or a saturated integer
                w_pend.malformed = !r_flags.digit || (!r_flags.dot && r_flags.ovf);
            end
            stt_pkg::MODE_COMMENT: w_pend.token_kind = stt_pkg::KIND_COMMENT;
            stt_pkg::MODE_SPACE:   w_pend.token_kind = stt_pkg::KIND_SPACE;
            default:               w_pend.token_kind = stt_pkg::KIND_SPACE;
        endcase
    end

    // end-of-stream token, or a symbol that is complete on arrival
    always_comb begin
        w_second              = '0;
        w_second.last_of_step = 1'b1;
        if (w_eos) begin
            w_second.token_kind   = stt_pkg::KIND_EOF;
            w_second.start_index  = w_byte_ext[stt_pkg::OUT_INDEX_W-1:0];
            w_second.start_row    = w_row_ext[stt_pkg::OUT_POS_W-1:0];
            w_second.start_column = w_col_ext[stt_pkg::OUT_POS_W-1:0];
        end else begin
            w_second.token_kind   = stt_pkg::KIND_SYMBOL;
            w_second.start_index  = w_byte_ext[stt_pkg::OUT_INDEX_W-1:0];
            w_second.token_length = stt_pkg::OUT_INDEX_W'(1);
            w_second.start_row    = w_row_ext[stt_pkg::OUT_POS_W-1:0];
            w_second.start_column = w_col_ext[stt_pkg::OUT_POS_W-1:0];
            w_second.symbol_byte  = w_c;
        end
    end

    always_comb begin
        w_push.first_vld  = w_fire && (w_eos || !w_cont) && w_pend_vld;
        w_push.second_vld = w_fire && (w_eos || (!w_cont && w_is_sym));
    end

    stt_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_first  (w_pend),
        .i_second (w_second),
        .o_count  (w_q_count),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_eos) |=> (r_byte_cnt == '0 && r_mode == stt_pkg::MODE_IDLE))
        else $error("end mark did not return the scanner to its start state");

    a_byte_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_eos) |=> (r_byte_cnt == INDEX_WIDTH'($past(r_byte_cnt) + INDEX_WIDTH'(1))))
        else $error("byte index did not advance by one");

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_fire) |=> (r_in_vld && $stable(r_in)))
        else $error("unscanned request lost or changed");

    a_ident_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == stt_pkg::MODE_IDENT) |-> (r_kw.prog != 4'd0))
        else $error("identifier open with no byte counted");

endmodule

// ===== test/source_text_tokenizer_test.sv =====
`timescale 1ns / 1ps

module source_text_tokenizer_test;

    // tracks the scanner state and keeps the tokens still owed by the block
    class token_predictor;
        stt_pkg::t_out  expected_tokens[$];
        int             failures;

        stt_pkg::t_mode mode;
        logic [31:0] tok_index;
        logic [31:0] byte_count;
        logic [23:0] tok_row;
        logic [23:0] tok_col;
        logic [23:0] row_count;
        logic [23:0] col_count;
        logic [63:0] acc;
        logic        neg;
        logic        dot;
        logic        digit_seen;
        logic        ovf;
        logic [3:0]  kw_len;
        logic        may_func;
        logic        may_ret;

        function new();
            failures = 0;
            clear();
        endfunction

        function void clear();
            mode       = stt_pkg::MODE_IDLE;
            tok_index  = '0;
            byte_count = '0;
            tok_row    = '0;
            tok_col    = '0;
            row_count  = '0;
            col_count  = '0;
            acc        = '0;
            neg        = 1'b0;
            dot        = 1'b0;
            digit_seen = 1'b0;
            ovf        = 1'b0;
            kw_len     = '0;
            may_func   = 1'b0;
            may_ret    = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function void emit(stt_pkg::t_kind k, logic [31:0] idx, logic [31:0] len,
                           logic [23:0] row, logic [23:0] col, logic [63:0] val,
                           logic [7:0] sym, logic bad);
            stt_pkg::t_out t;
            t.token_kind    = k;
            t.start_index   = idx;
            t.token_length  = len;
            t.start_row     = row;
            t.start_column  = col;
            t.integer_value = val;
            t.symbol_byte   = sym;
            t.malformed     = bad;
            t.last_of_step  = 1'b0;
            expected_tokens = {expected_tokens, t};
        endfunction

        // keyword match narrows with every identifier byte
        function void track_keyword(logic [7:0] c);
            string fw;
            string rw;
            fw = "function";
            rw = "return";
            if (!(kw_len < stt_pkg::KW_FUNC_LEN && c == fw[kw_len])) may_func = 1'b0;
            if (!(kw_len < stt_pkg::KW_RET_LEN && c == rw[kw_len])) may_ret = 1'b0;
            if (kw_len != 4'hF) kw_len = kw_len + 4'd1;
        endfunction

        // digits after the dot only mark the number as having digits
        function void push_digit(logic [7:0] c);
            logic [63:0] lim;
            logic [63:0] d;
            lim = neg ? stt_pkg::LIMIT_NEG : stt_pkg::LIMIT_POS;
            d = {56'd0, c - 8'h30};
            digit_seen = 1'b1;
            if (dot) return;
            if (acc > (lim - d) / 64'd10) begin
                acc = lim;
                ovf = 1'b1;
            end else begin
                acc = acc * 64'd10 + d;
            end
        endfunction

        function bit extends_token(logic [7:0] c);
            case (mode)
                stt_pkg::MODE_SPACE:   return is_blank(c);
                stt_pkg::MODE_IDENT:   return is_letter(c) || is_digit(c);
                stt_pkg::MODE_NUMBER:  return is_digit(c) || (c == stt_pkg::CHAR_DOT && !dot);
                stt_pkg::MODE_COMMENT: return c != stt_pkg::CHAR_LF && c != stt_pkg::CHAR_CR;
                default:               return 1'b0;
            endcase
        endfunction

        function void close_token();
            stt_pkg::t_kind k;
            logic [63:0]    v;
            logic           bad;
            v   = '0;
            bad = 1'b0;
            case (mode)
                stt_pkg::MODE_SPACE: k = stt_pkg::KIND_SPACE;
                stt_pkg::MODE_IDENT: begin
                    if (may_func && kw_len == stt_pkg::KW_FUNC_LEN) k = stt_pkg::KIND_FUNC;
                    else if (may_ret && kw_len == stt_pkg::KW_RET_LEN) k = stt_pkg::KIND_RETURN;
                    else k = stt_pkg::KIND_IDENT;
                end
                stt_pkg::MODE_NUMBER: begin
                    if (dot) begin
                        k = neg ? stt_pkg::KIND_NEG_DBL : stt_pkg::KIND_POS_DBL;
                    end else begin
                        k = neg ? stt_pkg::KIND_NEG_INT : stt_pkg::KIND_POS_INT;
                        v = neg ? -acc : acc;
                    end
                    bad = !digit_seen || (!dot && ovf);
                end
                stt_pkg::MODE_COMMENT: k = stt_pkg::KIND_COMMENT;
                default: return;
            endcase
            emit(k, tok_index, byte_count - tok_index, tok_row, tok_col, v, 8'h00, bad);
            mode = stt_pkg::MODE_IDLE;
        endfunction

        function void open_token(logic [7:0] c);
            tok_index = byte_count;
            tok_row   = row_count;
            tok_col   = col_count;
            if (is_blank(c)) begin
                mode = stt_pkg::MODE_SPACE;
            end else if (is_letter(c)) begin
                mode     = stt_pkg::MODE_IDENT;
                kw_len   = '0;
                may_func = 1'b1;
                may_ret  = 1'b1;
                track_keyword(c);
            end else if (is_digit(c) || c == stt_pkg::CHAR_DOT || c == stt_pkg::CHAR_MINUS) begin
                mode       = stt_pkg::MODE_NUMBER;
                acc        = '0;
                neg        = (c == stt_pkg::CHAR_MINUS);
                dot        = (c == stt_pkg::CHAR_DOT);
                digit_seen = 1'b0;
                ovf        = 1'b0;
                if (is_digit(c)) push_digit(c);
            end else if (c == stt_pkg::CHAR_HASH) begin
                mode = stt_pkg::MODE_COMMENT;
            end else begin
                mode = stt_pkg::MODE_IDLE;
                emit(stt_pkg::KIND_SYMBOL, byte_count, 32'd1, row_count, col_count, '0, c,
                     1'b0);
            end
        endfunction

        function void take_char(stt_pkg::t_in r);
            int before_n;
            before_n = expected_tokens.size();
            if (r.end_of_stream) begin
                close_token();
                emit(stt_pkg::KIND_EOF, byte_count, '0, row_count, col_count, '0, 8'h00,
                     1'b0);
                clear();
            end else begin
                if (mode != stt_pkg::MODE_IDLE && extends_token(r.char_code)) begin
                    if (mode == stt_pkg::MODE_IDENT) begin
                        track_keyword(r.char_code);
                    end else if (mode == stt_pkg::MODE_NUMBER) begin
                        if (r.char_code == stt_pkg::CHAR_DOT) dot = 1'b1;
                        else push_digit(r.char_code);
                    end
                end else begin
                    close_token();
                    open_token(r.char_code);
                end
                byte_count = byte_count + 32'd1;
                if (r.char_code == stt_pkg::CHAR_LF) begin
                    col_count = '0;
                    row_count = row_count + 24'd1;
                end else begin
                    col_count = col_count + 24'd1;
                end
            end
            if (expected_tokens.size() > before_n) begin
                expected_tokens[expected_tokens.size() - 1].last_of_step = 1'b1;
            end
        endfunction

        function void show_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        endfunction

        function void check_token(stt_pkg::t_out got);
            stt_pkg::t_out want;
            if (expected_tokens.size() == 0) begin
                $display("%0t: token with none expected: kind %0d index %0d",
                         $time, got.token_kind, got.start_index);
                failures++;
                return;
            end
            want = expected_tokens.pop_front();
            if (want !== got) begin
                failures++;
                show_field("token_kind", 64'(want.token_kind), 64'(got.token_kind));
                show_field("start_index", 64'(want.start_index), 64'(got.start_index));
                show_field("token_length", 64'(want.token_length), 64'(got.token_length));
                show_field("start_row", 64'(want.start_row), 64'(got.start_row));
                show_field("start_column", 64'(want.start_column), 64'(got.start_column));
                show_field("integer_value", want.integer_value, got.integer_value);
                show_field("symbol_byte", 64'(want.symbol_byte), 64'(got.symbol_byte));
                show_field("malformed", 64'(want.malformed), 64'(got.malformed));
                show_field("last_of_step", 64'(want.last_of_step), 64'(got.last_of_step));
            end
        endfunction
    endclass

    localparam int QUIET_LIMIT = 1000;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    stt_pkg::t_in  req_data  = '0;
    logic          tok_valid;
    logic          tok_ready = 1'b0;
    stt_pkg::t_out tok_data;

    token_predictor book;
    int   chars_sent = 0;
    int   quiet      = 0;
    bit   steady     = 1'b0;   // both sides run without gaps while set

    source_text_tokenizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (tok_valid),
        .i_out_ready (tok_ready),
        .o_out_data  (tok_data)
    );

    always #5 clk = ~clk;

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk) begin
        tok_ready <= steady || ($urandom_range(99) >= 23);
    end

    // requests go into the predictor before any token of the same edge is checked
    always @(posedge clk) begin
        if (rst_n && req_valid && req_ready) book.take_char(req_data);
        if (rst_n && tok_valid && tok_ready) book.check_token(tok_data);
    end

    // watchdog: consecutive cycles with no handshake on either side
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (tok_valid && tok_ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // one request: optional idle gap, then hold valid until taken; called on a falling edge
    task automatic send_char(input logic [7:0] c, input logic eos);
        while (!steady && $urandom_range(99) < 23) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= {c, eos};
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    endtask

    // end mark carries a random byte, which the block must ignore
    task automatic send_end();
        send_char(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? 8'h61 : 8'h41;
        return base + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] any_alnum();
        int r;
        r = $urandom_range(61);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h61 + (r - 10));
        return 8'(8'h41 + (r - 36));
    endfunction

    function automatic logic [7:0] any_blank();
        case ($urandom_range(5))
            0:       return 8'h09;
            1:       return stt_pkg::CHAR_LF;
            2:       return 8'h0B;
            3:       return 8'h0C;
            4:       return stt_pkg::CHAR_CR;
            default: return 8'h20;
        endcase
    endfunction

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++) send_char(8'h30 + 8'($urandom_range(9)), 1'b0);
    endtask

    // numbers: mostly short, some long enough to saturate, some right on the limits
    task automatic send_number();
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(5))
                0: send_text("9223372036854775807");
                1: send_text("9223372036854775808");
                2: send_text("-9223372036854775808");
                3: send_text("-9223372036854775809");
                4: send_text("99999999999999999999999");
                default: send_text("-000000000000000000000000012");
            endcase
        end else begin
            if ($urandom_range(2) == 0) send_char(stt_pkg::CHAR_MINUS, 1'b0);
            send_digits(($urandom_range(99) < 10) ? $urandom_range(22, 17) : $urandom_range(4));
            if ($urandom_range(2) == 0) begin
                send_char(stt_pkg::CHAR_DOT, 1'b0);
                send_digits($urandom_range(3));
                // second dot starts a fresh number
                if ($urandom_range(5) == 0) begin
                    send_char(stt_pkg::CHAR_DOT, 1'b0);
                    send_digits($urandom_range(2));
                end
            end
        end
    endtask

    task automatic send_keyword();
        string w;
        w = $urandom_range(1) ? "function" : "return";
        case ($urandom_range(5))
            0: begin
                // truncated keyword is a plain identifier
                for (int i = 0; i < $urandom_range(w.len() - 1, 1); i++) send_char(w[i], 1'b0);
            end
            1: begin
                send_text(w);
                send_char(any_alnum(), 1'b0);
            end
            default: send_text(w);
        endcase
    endtask

    task automatic send_comment();
        send_char(stt_pkg::CHAR_HASH, 1'b0);
        for (int i = 0; i < $urandom_range(8); i++)
            send_char(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(126, 32)), 1'b0);
        case ($urandom_range(2))
            0:       send_char(stt_pkg::CHAR_LF, 1'b0);
            1:       send_char(stt_pkg::CHAR_CR, 1'b0);
            default: ;
        endcase
    endtask

    // one well-formed piece of source text, or noise
    task automatic send_random_piece();
        int r;
        r = $urandom_range(99);
        if (r < 14) begin
            send_keyword();
        end else if (r < 26) begin
            send_char(any_letter(), 1'b0);
            for (int i = 0; i < $urandom_range(6); i++) send_char(any_alnum(), 1'b0);
        end else if (r < 48) begin
            send_number();
        end else if (r < 66) begin
            for (int i = 0; i < $urandom_range(4, 1); i++) send_char(any_blank(), 1'b0);
        end else if (r < 74) begin
            send_comment();
        end else if (r < 86) begin
            send_char(8'($urandom_range(255)), 1'b0);
        end else if (r < 90) begin
            send_end();
        end else begin
            for (int i = 0; i < $urandom_range(4, 1); i++)
                send_char(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial begin
        bit drained;
        drained = 1'b0;
        book = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // keyword, number cut by a second dot, lone dot, lone minus,
        // comment closed by carriage return, high and zero bytes as symbols
        send_text("function 1.2.-#a");
        send_char(stt_pkg::CHAR_CR, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_text("x9");
        send_end();

        while (chars_sent < 1400) begin
            steady = (chars_sent >= 500 && chars_sent < 800);
            // hold off once until the block has handed over everything owed
            if (!drained && chars_sent >= 1000) begin
                req_valid <= 1'b0;
                do @(negedge clk); while (book.expected_tokens.size() != 0);
                drained = 1'b1;
            end
            send_random_piece();
        end
        steady = 1'b0;
        send_end();
        req_valid <= 1'b0;

        while (book.expected_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (book.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== source_text_tokenizer.f =====
rtl/stt_pkg.sv
rtl/stt_result_queue.sv
rtl/source_text_tokenizer.sv
test/source_text_tokenizer_test.sv
